[design/bfra_pkg.sv]
// shared types and codes for the best-fit range allocator
// no dependencies; imported by bfra_cell and best_fit_range_allocator
package bfra_pkg;

	// request kinds carried in s_tuser
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// error codes reported with each result
	localparam logic ERR_NONE       = 1'b0;
	localparam logic ERR_TABLE_FULL = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

endpackage

[design/bfra_cell.sv]
// one cell of the free range chain: holds one range, folds its range into the
// search token passed from its lower neighbor and shifts on insert or remove
// depends on bfra_pkg; token and update types come in as type parameters
module bfra_cell #(
	parameter int ADDR_WIDTH = 32,
	parameter int IW = 7,
	parameter int CW = 32,
	parameter int IDX = 0,
	parameter type tok_t = logic,
	parameter type upd_t = logic
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op,
	input  logic [CW-1:0]         size,
	input  logic [ADDR_WIDTH-1:0] first,
	input  logic [IW-1:0]         count,
	input  tok_t                  tok_in,
	output tok_t                  tok_out,
	input  logic                  apply,
	input  upd_t                  upd,
	input  logic [ADDR_WIDTH-1:0] dn_start,
	input  logic [ADDR_WIDTH-1:0] dn_end,
	input  logic [ADDR_WIDTH-1:0] up_start,
	input  logic [ADDR_WIDTH-1:0] up_end,
	output logic [ADDR_WIDTH-1:0] start_q,
	output logic [ADDR_WIDTH-1:0] end_q
);
	import bfra_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic                  valid;
	logic [ADDR_WIDTH-1:0] rsize;
	logic [CW-1:0]         rsize_w;
	tok_t                  tok_d;
	tok_t                  tok_q;

	assign valid   = MY_IDX < count;
	assign rsize   = end_q - start_q + 1'b1;
	assign rsize_w = CW'(rsize);

	// fold this range into the search token
	always_comb begin
		tok_d = tok_in;
		if (valid) begin
			if (op == OP_ALLOC && !tok_in.eq) begin
				if (rsize_w == size) begin
					tok_d.found      = 1'b1;
					tok_d.eq         = 1'b1;
					tok_d.pick       = MY_IDX;
					tok_d.best       = rsize;
					tok_d.best_start = start_q;
				end else if (rsize_w > size && (!tok_in.found || rsize < tok_in.best)) begin
					tok_d.found      = 1'b1;
					tok_d.pick       = MY_IDX;
					tok_d.best       = rsize;
					tok_d.best_start = start_q;
				end
			end
			if (op == OP_RELEASE && !tok_in.pfound) begin
				if (first < start_q) begin
					tok_d.pfound   = 1'b1;
					tok_d.pos      = MY_IDX;
					tok_d.start_at = start_q;
					tok_d.end_at   = end_q;
				end else begin
					tok_d.lower      = 1'b1;
					tok_d.end_before = end_q;
				end
			end
		end
	end

	// token register toward the upper neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end
	assign tok_out = tok_q;

	// range storage with neighbor shifts
	always_ff @(posedge clk) begin
		if (apply) begin
			if (upd.rm && MY_IDX >= upd.rm_idx) begin
				start_q <= up_start;
				end_q   <= up_end;
			end else if (upd.ins && MY_IDX > upd.ins_idx) begin
				start_q <= dn_start;
				end_q   <= dn_end;
			end else begin
				if (upd.ws && MY_IDX == upd.ws_idx) start_q <= upd.ws_val;
				if (upd.we && MY_IDX == upd.we_idx) end_q <= upd.we_val;
			end
		end
	end

endmodule

[design/best_fit_range_allocator.sv]
// best-fit free range allocator built as a chain of range cells
// a request's search token crosses the chain one cell per cycle, then the
// update state applies the table change and registers the result
// one request at a time: s_tready is high only while idle; an untaken result
// holds the update state and stalls the input
// reset: asynchronous, clears range count, sequencer, handshake and cell tokens
module best_fit_range_allocator #(
	parameter int MAX_RANGES = 64,
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // req_size[31:0], first_addr[63:32], last_addr[95:64]
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // granted[0], grant_start[32:1], grant_end[64:33],
	                              // error_code[65], zero pad[71:66]
);
	import bfra_pkg::*;

	localparam int IW = $clog2(MAX_RANGES + 1);
	localparam int CW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
	localparam logic [IW-1:0] FULL = IW'(MAX_RANGES);

	typedef struct packed {
		logic                  found;
		logic                  eq;
		logic [IW-1:0]         pick;
		logic [ADDR_WIDTH-1:0] best;
		logic [ADDR_WIDTH-1:0] best_start;
		logic                  pfound;
		logic                  lower;
		logic [IW-1:0]         pos;
		logic [ADDR_WIDTH-1:0] end_before;
		logic [ADDR_WIDTH-1:0] start_at;
		logic [ADDR_WIDTH-1:0] end_at;
	} tok_t;

	typedef struct packed {
		logic                  rm;
		logic [IW-1:0]         rm_idx;
		logic                  ins;
		logic [IW-1:0]         ins_idx;
		logic                  ws;
		logic [IW-1:0]         ws_idx;
		logic [ADDR_WIDTH-1:0] ws_val;
		logic                  we;
		logic [IW-1:0]         we_idx;
		logic [ADDR_WIDTH-1:0] we_val;
	} upd_t;

	state_t state_q, state_d;
	logic [IW-1:0] count_q, count_d;
	logic [IW-1:0] scan_q;
	logic op_q;
	logic [CW-1:0] size_q;
	logic [ADDR_WIDTH-1:0] first_q, last_q;
	logic m_tvalid_q;
	logic [71:0] m_tdata_q;

	logic apply;
	logic accept;
	upd_t upd;
	tok_t tok_init;
	tok_t tok_fin;
	tok_t tok_chain [MAX_RANGES+1];
	logic [ADDR_WIDTH-1:0] cstart [MAX_RANGES];
	logic [ADDR_WIDTH-1:0] cend [MAX_RANGES];

	logic grant;
	logic [CW-1:0] gs_w, ge_w;
	logic below, above, err;
	logic [71:0] res_d;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			size_q  <= CW'(s_tdata[31:0]);
			first_q <= ADDR_WIDTH'(s_tdata[63:32]);
			last_q  <= ADDR_WIDTH'(s_tdata[95:64]);
		end
	end

	// token entering the bottom cell
	always_comb begin
		tok_init     = '0;
		tok_init.pos = count_q;
	end
	assign tok_chain[0] = tok_init;
	assign tok_fin      = tok_chain[MAX_RANGES];

	// cell chain
	for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
		logic [ADDR_WIDTH-1:0] dn_s, dn_e, up_s, up_e;
		if (k == 0) begin : g_lo
			assign dn_s = cstart[k];
			assign dn_e = cend[k];
		end else begin : g_mid
			assign dn_s = cstart[k-1];
			assign dn_e = cend[k-1];
		end
		if (k == MAX_RANGES - 1) begin : g_hi
			assign up_s = cstart[k];
			assign up_e = cend[k];
		end else begin : g_nxt
			assign up_s = cstart[k+1];
			assign up_e = cend[k+1];
		end
		bfra_cell #(
			.ADDR_WIDTH(ADDR_WIDTH),
			.IW        (IW),
			.CW        (CW),
			.IDX       (k),
			.tok_t     (tok_t),
			.upd_t     (upd_t)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op_q),
			.size    (size_q),
			.first   (first_q),
			.count   (count_q),
			.tok_in  (tok_chain[k]),
			.tok_out (tok_chain[k+1]),
			.apply   (apply),
			.upd     (upd),
			.dn_start(dn_s),
			.dn_end  (dn_e),
			.up_start(up_s),
			.up_end  (up_e),
			.start_q (cstart[k]),
			.end_q   (cend[k])
		);
	end

	// decide the table update and the result from the finished token
	always_comb begin
		upd     = '0;
		count_d = count_q;
		grant   = 1'b0;
		below   = 1'b0;
		above   = 1'b0;
		err     = ERR_NONE;
		gs_w    = CW'(tok_fin.best_start);
		ge_w    = CW'(ADDR_WIDTH'(gs_w + size_q - 1'b1));
		if (op_q == OP_ALLOC) begin
			grant = (size_q != '0) && tok_fin.found;
			if (grant) begin
				if (tok_fin.eq) begin
					upd.rm     = 1'b1;
					upd.rm_idx = tok_fin.pick;
					count_d    = count_q - 1'b1;
				end else begin
					upd.ws     = 1'b1;
					upd.ws_idx = tok_fin.pick;
					upd.ws_val = ADDR_WIDTH'(gs_w + size_q);
				end
			end
		end else begin
			below = tok_fin.lower && (tok_fin.end_before != '1) &&
			        (first_q == tok_fin.end_before + 1'b1);
			above = tok_fin.pfound && (tok_fin.start_at != '0) &&
			        (last_q == tok_fin.start_at - 1'b1);
			if (below && above) begin
				upd.we     = 1'b1;
				upd.we_idx = tok_fin.pos - 1'b1;
				upd.we_val = tok_fin.end_at;
				upd.rm     = 1'b1;
				upd.rm_idx = tok_fin.pos;
				count_d    = count_q - 1'b1;
			end else if (below) begin
				upd.we     = 1'b1;
				upd.we_idx = tok_fin.pos - 1'b1;
				upd.we_val = last_q;
			end else if (above) begin
				upd.ws     = 1'b1;
				upd.ws_idx = tok_fin.pos;
				upd.ws_val = first_q;
			end else if (count_q < FULL) begin
				upd.ins     = 1'b1;
				upd.ins_idx = tok_fin.pos;
				upd.ws      = 1'b1;
				upd.ws_idx  = tok_fin.pos;
				upd.ws_val  = first_q;
				upd.we      = 1'b1;
				upd.we_idx  = tok_fin.pos;
				upd.we_val  = last_q;
				count_d     = count_q + 1'b1;
			end else begin
				err = ERR_TABLE_FULL;
			end
		end
		res_d = '0;
		res_d[0]     = grant;
		res_d[32:1]  = grant ? gs_w[31:0] : 32'd0;
		res_d[64:33] = grant ? ge_w[31:0] : 32'd0;
		res_d[65]    = err;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		apply   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_q == FULL - 1'b1) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (!m_tvalid_q || m_tready) begin
					apply   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer, count and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) scan_q <= scan_q + 1'b1;
			else scan_q <= '0;
			if (apply) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (apply) m_tdata_q <= res_d;
	end

endmodule
